// ===== rtl/core/stq_pkg.sv =====
package stq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int LINK_W      = $clog2(TIMER_SLOTS + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(TIMER_SLOTS);

    // Tick period is 720896/13125 ms; 720896 = 11 << 16 = 54 * 13125 + 12146.
    localparam int MS_TO_TICK_MUL = 13125;
    localparam int TICK_SHIFT     = 16;
    localparam int TICK_MS_DIV    = 13125;
    localparam int TICK_MS_INT    = 54;
    localparam int TICK_MS_FRAC   = 12146;

    // Reciprocals for exact division of values below 2^30.
    localparam int RECIP_11       = 1561806290;
    localparam int RECIP_11_SHIFT = 34;
    localparam int RECIP_MS       = 1340357032;
    localparam int RECIP_MS_SHIFT = 44;

    typedef enum logic [2:0] {
        ACT_SET   = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_READ  = 3'd3,
        ACT_TICK  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_EXPIRED = 2'd1,
        KIND_READ    = 2'd2,
        KIND_DONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_STOP   = 2'd0,
        ST_RUN    = 2'd1,
        ST_EXPIRE = 2'd2
    } slot_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SET_MUL,
        S_DIV,
        S_DIV_REM,
        S_DIV_DONE,
        S_UN_INIT,
        S_UN_RD,
        S_UN_CHK,
        S_START,
        S_INS_RD,
        S_INS_CHK,
        S_INS_LINK,
        S_READ_RD,
        S_READ_CHK,
        S_READ_DUR,
        S_TICK_HEAD,
        S_TICK_RD,
        S_TICK_CHK,
        S_TICK_DONE,
        S_ACK
    } state_t;

endpackage

// ===== rtl/core/sorted_timer_queue_engine.sv =====
// Channel | Signals                                        | Direction
// req     | req_valid req_ready action timer_id interval_ms | into block
// rsp     | rsp_valid rsp_ready kind slot_id remaining_ms   | out of block
//         | duration_ms last                               |
//
// One command at a time; req_ready is high only while the sequencer is idle.
// Each ms/tick conversion runs the shared 30x31 reciprocal multiplier once
// per 16-bit digit (one pass for set, two per value for read), each pass
// followed by a remainder step. Start and stop walk the list one entry at a
// time, a read state then a check state per entry (registered RAM read);
// tick runs head, read and check states per expired slot, then the done beat.
// Reset clears the clock, slot status, durations and the list head; the expiry
// and link RAMs are not reset, and read ignores the expiry of a slot that is
// not running. A stalled rsp beat holds the sequencer in place until it is taken.
module sorted_timer_queue_engine
    import stq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  action,
    input  logic [3:0]  timer_id,
    input  logic [31:0] interval_ms,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  kind,
    output logic [3:0]  slot_id,
    output logic [31:0] remaining_ms,
    output logic [31:0] duration_ms,
    output logic        last
);

    state_t state_reg, state_next;

    // Latched command.
    action_t     act_reg, act_next;
    logic [3:0]  id_reg, id_next;
    logic [31:0] ms_reg, ms_next;
    logic        ok_reg, ok_next;

    // Timer state.
    logic [31:0]       tick_reg, tick_next;
    logic [LINK_W-1:0] head_reg, head_next;
    slot_status_t      status_reg [TIMER_SLOTS];
    logic [31:0]       dur_reg    [TIMER_SLOTS];

    // List walker.
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [LINK_W-1:0] n_reg, n_next;
    logic [31:0]       exp_new_reg, exp_new_next;

    // Shared reciprocal divider.
    logic [29:0]          w_reg, w_next;
    logic [15:0]          lo_reg, lo_next;
    logic [31:0]          q_reg, q_next;
    logic [31:0]          acc_reg, acc_next;
    logic                 step_reg, step_next;
    logic                 div_small_reg, div_small_next;
    logic                 phase_reg, phase_next;
    logic                 rem_ok_reg, rem_ok_next;
    logic [31:0]          rem_ms_reg, rem_ms_next;

    // Output register.
    logic        rsp_valid_reg;
    kind_t       kind_reg;
    logic [3:0]  slot_id_reg;
    logic [31:0] remaining_reg, duration_reg;
    logic        last_reg;
    logic        out_load;
    kind_t       out_kind;
    logic [3:0]  out_id;
    logic [31:0] out_rem, out_dur;
    logic        out_last;
    logic        out_free;

    // Slot register writes.
    logic              status_we;
    logic [SLOT_W-1:0] status_widx;
    slot_status_t      status_wdata;
    logic              dur_we;
    logic [31:0]       dur_wdata;

    // RAM ports.
    logic              exp_we, link_we;
    logic [SLOT_W-1:0] exp_waddr, link_waddr, rd_addr;
    logic [31:0]       exp_wdata, exp_rd;
    logic [LINK_W-1:0] link_wdata, link_rd, link_sat;

    logic [SLOT_W-1:0]     idx, cur_idx;
    logic [30:0]           recip_k;
    logic [60:0]           recip_prod;
    logic [29:0]           r_full;
    logic [31:0]           diff;
    logic [31:0]           conv_in;
    logic [45:0]           ms_prod;
    logic [45:0]           frac_prod;

    assign idx     = id_reg[SLOT_W-1:0];
    assign cur_idx = cur_reg[SLOT_W-1:0];
    assign rd_addr = cur_idx;
    assign link_sat = (link_rd > NULL_LINK) ? NULL_LINK : link_rd;
    assign out_free = !rsp_valid_reg || rsp_ready;

    stq_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_exp_ram (
        .clk   (clk),
        .we    (exp_we),
        .waddr (exp_waddr),
        .wdata (exp_wdata),
        .raddr (rd_addr),
        .rdata (exp_rd)
    );

    stq_ram #(.WIDTH(LINK_W), .DEPTH(TIMER_SLOTS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (link_rd)
    );

    // Shared multiplier: quotient of w by 11 (set) or 13125 (read) by reciprocal.
    assign recip_k    = div_small_reg ? 31'(RECIP_11) : 31'(RECIP_MS);
    assign recip_prod = 61'(w_reg) * 61'(recip_k);

    // ms to ticks: scale first, then divide by 11.
    assign ms_prod   = 46'(ms_reg) * 46'(MS_TO_TICK_MUL);
    // ticks to ms: 54*v plus the fractional part 12146*v/13125.
    assign conv_in   = (state_reg == S_READ_DUR) ? dur_reg[idx] : (exp_rd - tick_reg);
    assign frac_prod = 46'(conv_in) * 46'(TICK_MS_FRAC);

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        id_next        = id_reg;
        ms_next        = ms_reg;
        ok_next        = ok_reg;
        tick_next      = tick_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        n_next         = n_reg;
        exp_new_next   = exp_new_reg;
        w_next         = w_reg;
        lo_next        = lo_reg;
        q_next         = q_reg;
        acc_next       = acc_reg;
        step_next      = step_reg;
        div_small_next = div_small_reg;
        phase_next     = phase_reg;
        rem_ok_next    = rem_ok_reg;
        rem_ms_next    = rem_ms_reg;
        out_load       = 1'b0;
        out_kind       = KIND_ACK;
        out_id         = id_reg;
        out_rem        = '0;
        out_dur        = '0;
        out_last       = 1'b1;
        status_we      = 1'b0;
        status_widx    = idx;
        status_wdata   = ST_STOP;
        dur_we         = 1'b0;
        dur_wdata      = '0;
        exp_we         = 1'b0;
        exp_waddr      = idx;
        exp_wdata      = exp_new_reg;
        link_we        = 1'b0;
        link_waddr     = idx;
        link_wdata     = cur_reg;
        req_ready      = 1'b0;
        diff           = '0;
        r_full         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    act_next   = action_t'(action);
                    id_next    = timer_id;
                    ms_next    = interval_ms;
                    ok_next    = ({1'b0, timer_id} < 5'(TIMER_SLOTS));
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                n_next    = '0;
                prev_next = NULL_LINK;
                unique case (act_reg)
                    ACT_TICK:
                    begin
                        tick_next  = tick_reg + 32'd1;
                        state_next = S_TICK_HEAD;
                    end
                    ACT_READ:
                    begin
                        cur_next   = LINK_W'(id_reg);
                        state_next = ok_reg ? S_READ_RD : S_DIV_DONE;
                        phase_next = 1'b1;
                        rem_ok_next = 1'b0;
                        acc_next   = '0;
                    end
                    ACT_SET:   state_next = ok_reg ? S_SET_MUL : S_ACK;
                    ACT_START,
                    ACT_STOP:  state_next = ok_reg ? S_UN_INIT : S_ACK;
                    default:   state_next = S_ACK;
                endcase
            end

            // Set: ms * 13125 >> 16, then divide by 11.
            S_SET_MUL:
            begin
                w_next         = ms_prod[45:TICK_SHIFT];
                div_small_next = 1'b1;
                state_next     = S_DIV;
            end

            S_DIV:
            begin
                q_next     = div_small_reg ? 32'(recip_prod[60:RECIP_11_SHIFT])
                                           : 32'(recip_prod[60:RECIP_MS_SHIFT]);
                state_next = S_DIV_REM;
            end

            // Fold the quotient in; on the high digit carry the remainder down.
            S_DIV_REM:
            begin
                if (div_small_reg)
                begin
                    acc_next   = q_reg;
                    state_next = S_DIV_DONE;
                end
                else if (!step_reg)
                begin
                    r_full     = w_reg - 30'(q_reg[16:0] * 31'(TICK_MS_DIV));
                    w_next     = {r_full[13:0], lo_reg};
                    acc_next   = acc_reg + {q_reg[15:0], 16'd0};
                    step_next  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    acc_next   = acc_reg + q_reg;
                    state_next = S_DIV_DONE;
                end
            end

            S_DIV_DONE:
            begin
                if (act_reg == ACT_SET)
                begin
                    dur_we     = 1'b1;
                    dur_wdata  = (ms_reg == 32'd0) ? 32'd0 : (acc_reg + 32'd1);
                    state_next = S_ACK;
                end
                else if (!phase_reg)
                begin
                    rem_ms_next = rem_ok_reg ? acc_reg : 32'd0;
                    state_next  = S_READ_DUR;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    out_kind   = KIND_READ;
                    out_rem    = ok_reg ? rem_ms_reg : 32'd0;
                    out_dur    = ok_reg ? acc_reg : 32'd0;
                    state_next = S_IDLE;
                end
            end

            // Unlink the slot if it is running.
            S_UN_INIT:
            begin
                cur_next   = head_reg;
                state_next = (status_reg[idx] == ST_RUN) ? S_UN_RD : S_START;
            end

            S_UN_RD: state_next = S_UN_CHK;

            S_UN_CHK:
            begin
                if (cur_reg >= NULL_LINK || n_reg == LINK_W'(TIMER_SLOTS))
                begin
                    state_next = S_START;
                end
                else if (cur_reg == LINK_W'(id_reg))
                begin
                    if (prev_reg == NULL_LINK)
                    begin
                        head_next = link_rd;
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg[SLOT_W-1:0];
                        link_wdata = link_rd;
                    end
                    status_we    = 1'b1;
                    status_wdata = ST_STOP;
                    state_next   = S_START;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd;
                    n_next     = n_reg + 1'b1;
                    state_next = S_UN_RD;
                end
            end

            S_START:
            begin
                cur_next  = head_reg;
                prev_next = NULL_LINK;
                n_next    = '0;
                if (act_reg != ACT_START || dur_reg[idx] == 32'd0)
                begin
                    state_next = S_ACK;
                end
                else
                begin
                    exp_new_next = tick_reg + dur_reg[idx];
                    exp_we       = 1'b1;
                    exp_wdata    = tick_reg + dur_reg[idx];
                    status_we    = 1'b1;
                    status_wdata = ST_RUN;
                    state_next   = S_INS_RD;
                end
            end

            S_INS_RD: state_next = S_INS_CHK;

            // Insert ahead of the first entry not earlier than the new expiry.
            S_INS_CHK:
            begin
                diff = exp_rd - exp_new_reg;
                if (cur_reg >= NULL_LINK || n_reg == LINK_W'(TIMER_SLOTS) || !diff[31])
                begin
                    if (prev_reg == NULL_LINK)
                    begin
                        head_next = LINK_W'(id_reg);
                    end
                    else
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg[SLOT_W-1:0];
                        link_wdata = LINK_W'(id_reg);
                    end
                    if (cur_reg >= NULL_LINK)
                    begin
                        cur_next = NULL_LINK;
                    end
                    state_next = S_INS_LINK;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd;
                    n_next     = n_reg + 1'b1;
                    state_next = S_INS_RD;
                end
            end

            S_INS_LINK:
            begin
                link_we    = 1'b1;
                link_waddr = idx;
                link_wdata = cur_reg;
                state_next = S_ACK;
            end

            S_READ_RD: state_next = S_READ_CHK;

            S_READ_CHK:
            begin
                diff           = exp_rd - tick_reg;
                rem_ok_next    = (status_reg[idx] == ST_RUN) && (diff != 32'd0) && !diff[31];
                w_next         = frac_prod[45:TICK_SHIFT];
                lo_next        = frac_prod[TICK_SHIFT-1:0];
                acc_next       = conv_in * 32'(TICK_MS_INT);
                step_next      = 1'b0;
                div_small_next = 1'b0;
                phase_next     = 1'b0;
                state_next     = S_DIV;
            end

            S_READ_DUR:
            begin
                w_next     = frac_prod[45:TICK_SHIFT];
                lo_next    = frac_prod[TICK_SHIFT-1:0];
                acc_next   = conv_in * 32'(TICK_MS_INT);
                step_next  = 1'b0;
                phase_next = 1'b1;
                state_next = S_DIV;
            end

            S_TICK_HEAD:
            begin
                cur_next = head_reg;
                if (head_reg >= NULL_LINK || n_reg == LINK_W'(TIMER_SLOTS))
                begin
                    state_next = S_TICK_DONE;
                end
                else
                begin
                    state_next = S_TICK_RD;
                end
            end

            S_TICK_RD: state_next = S_TICK_CHK;

            S_TICK_CHK:
            begin
                diff = tick_reg - exp_rd;
                if (diff[31])
                begin
                    state_next = S_TICK_DONE;
                end
                else if (out_free)
                begin
                    head_next    = link_sat;
                    status_we    = 1'b1;
                    status_widx  = cur_idx;
                    status_wdata = ST_EXPIRE;
                    out_load     = 1'b1;
                    out_kind     = KIND_EXPIRED;
                    out_id       = 4'(cur_idx);
                    out_last     = 1'b0;
                    n_next       = n_reg + 1'b1;
                    state_next   = S_TICK_HEAD;
                end
            end

            S_TICK_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_kind   = KIND_DONE;
                    out_id     = '0;
                    state_next = S_IDLE;
                end
            end

            S_ACK:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            head_reg      <= NULL_LINK;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < TIMER_SLOTS; i++)
            begin
                status_reg[i] <= ST_STOP;
                dur_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
            head_reg  <= head_next;
            if (status_we)
            begin
                status_reg[status_widx] <= status_wdata;
            end
            if (dur_we)
            begin
                dur_reg[idx] <= dur_wdata;
            end
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        id_reg        <= id_next;
        ms_reg        <= ms_next;
        ok_reg        <= ok_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        n_reg         <= n_next;
        exp_new_reg   <= exp_new_next;
        w_reg         <= w_next;
        lo_reg        <= lo_next;
        q_reg         <= q_next;
        acc_reg       <= acc_next;
        step_reg      <= step_next;
        div_small_reg <= div_small_next;
        phase_reg     <= phase_next;
        rem_ok_reg    <= rem_ok_next;
        rem_ms_reg    <= rem_ms_next;
        if (out_load)
        begin
            kind_reg      <= out_kind;
            slot_id_reg   <= out_id;
            remaining_reg <= out_rem;
            duration_reg  <= out_dur;
            last_reg      <= out_last;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign kind         = kind_reg;
    assign slot_id      = slot_id_reg;
    assign remaining_ms = remaining_reg;
    assign duration_ms  = duration_reg;
    assign last         = last_reg;

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= NULL_LINK)
        else $error("list head out of range");

    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |=> state_reg == S_DIV_REM)
        else $error("divider pass skipped its remainder step");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && kind == KIND_DONE) |-> last)
        else $error("tick done beat without last");

    a_expired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && kind == KIND_EXPIRED) |-> !last)
        else $error("expired beat marked last");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result overwrote a pending beat");

endmodule

// ===== rtl/core/stq_ram.sv =====
module stq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
